/* sv/pps_pkg.sv */
package pps_pkg;

  // time counter width and its saturation point
  localparam int unsigned TIME_W = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = 21'h1F_FFFF;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // input word
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  entry_index;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  priority_req;
  } in_item_t;

  // result word
  typedef struct packed {
    logic              ran_valid;
    logic [3:0]        ran_index;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_item_t;

  // best candidate so far, handed from cell to cell during a scan
  typedef struct packed {
    logic        found;
    logic [7:0]  pri;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic        last;   // candidate has one tick of service left
    logic [1:0]  cnt;    // pending entries seen, saturating at two
  } scan_token_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load;
    logic restart;
    logic upd;
  } cell_ctrl_t;

endpackage

/* sv/preemptive_priority_scheduler.sv */
// a tick word's result word is registered after its candidate token has walked
//   the row of entry cells one cell per cycle; busy is high meanwhile, so no new
//   word is accepted until the scan is through
// load and restart words give no result and keep busy low
// reset clears time, completion marks and process count; entry fields start undefined
// results are strobed on out_valid for one cycle and the receiver cannot stall
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pps_pkg::in_item_t   in_data,
  output logic                out_valid,
  output pps_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_TASKS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [4:0]                  pc_r;
  logic [pps_pkg::TIME_W-1:0]  time_r;
  logic [pps_pkg::TIME_W-1:0]  time_nxt;
  logic [pps_pkg::TIME_W-1:0]  time_inc;
  logic [pps_pkg::TIME_W-1:0]  ta;
  logic [pps_pkg::TIME_W-1:0]  wt;
  logic                        out_valid_r;
  pps_pkg::out_item_t          out_data_r;
  pps_pkg::out_item_t          out_nxt;
  logic                        accept;
  logic                        go;
  pps_pkg::cell_ctrl_t         ctrl;
  logic                        tail_valid;
  pps_pkg::scan_token_t        tail_tok;
  logic [IDX_W-1:0]            tail_idx;

  logic                        chain_valid [MAX_TASKS+1];
  pps_pkg::scan_token_t        chain_tok   [MAX_TASKS+1];
  logic [IDX_W-1:0]            chain_idx   [MAX_TASKS+1];

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;
  assign go     = accept && (in_data.action == pps_pkg::ACT_TICK);

  // commands to the cells
  always_comb begin
    ctrl.load    = accept && (in_data.action == pps_pkg::ACT_LOAD);
    ctrl.restart = accept && (in_data.action == pps_pkg::ACT_RESTART);
    ctrl.upd     = tail_valid && tail_tok.found;
  end

  // head of the chain: empty candidate
  assign chain_valid[0] = go;
  assign chain_tok[0]   = '0;
  assign chain_idx[0]   = '0;

  // row of entry cells
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    pps_cell #(
      .POS   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .item          (in_data),
      .upd_idx       (tail_idx),
      .pc            (pc_r),
      .cur_time      (time_r),
      .tok_in_valid  (chain_valid[i]),
      .tok_in        (chain_tok[i]),
      .idx_in        (chain_idx[i]),
      .tok_out_valid (chain_valid[i+1]),
      .tok_out       (chain_tok[i+1]),
      .idx_out       (chain_idx[i+1])
    );
  end

  assign tail_valid = chain_valid[MAX_TASKS];
  assign tail_tok   = chain_tok[MAX_TASKS];
  assign tail_idx   = chain_idx[MAX_TASKS];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // turnaround and waiting of a finishing task
  assign time_inc = (time_r == pps_pkg::TIME_MAX) ? time_r : time_r + 21'd1;
  assign ta = (time_inc >= 21'(tail_tok.arrival)) ? time_inc - 21'(tail_tok.arrival) : '0;
  assign wt = (ta >= 21'(tail_tok.burst)) ? ta - 21'(tail_tok.burst) : '0;

  // result word and time update at the end of a scan
  always_comb begin
    out_nxt  = '0;
    time_nxt = time_r;
    if (tail_tok.cnt == 2'd0) begin
      out_nxt.all_done = 1'b1;
    end else begin
      time_nxt = time_inc;
      if (tail_tok.found) begin
        out_nxt.ran_valid = 1'b1;
        out_nxt.ran_index = 4'(tail_idx);
        out_nxt.finished  = tail_tok.last;
        if (tail_tok.last) begin
          out_nxt.turnaround = ta;
          out_nxt.waiting    = wt;
        end
        out_nxt.all_done = (tail_tok.cnt == 2'd1) && tail_tok.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= tail_valid;
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      if (ctrl.restart) begin
        time_r <= '0;
      end else if (tail_valid) begin
        time_r <= time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_valid) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SCAN))
    else $error("result word without a scan");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid |-> (state_r == ST_SCAN))
    else $error("token reached the end outside a scan");

  a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finished) |-> out_data_r.ran_valid)
    else $error("finish reported for an idle tick");

  a_idle_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.all_done && !out_data_r.ran_valid)
      |-> (time_r == $past(time_r)))
    else $error("time moved on a tick with nothing pending");

endmodule

/* sv/pps_cell.sv */
module pps_cell #(
  parameter int POS   = 0,
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pps_pkg::cell_ctrl_t           ctrl,
  input  pps_pkg::in_item_t             item,
  input  logic [IDX_W-1:0]              upd_idx,
  input  logic [4:0]                    pc,
  input  logic [pps_pkg::TIME_W-1:0]    cur_time,
  input  logic                          tok_in_valid,
  input  pps_pkg::scan_token_t          tok_in,
  input  logic [IDX_W-1:0]              idx_in,
  output logic                          tok_out_valid,
  output pps_pkg::scan_token_t          tok_out,
  output logic [IDX_W-1:0]              idx_out
);

  logic [15:0]          arr_r;
  logic [15:0]          bur_r;
  logic [7:0]           pri_r;
  logic [15:0]          rem_r;
  logic                 done_r;
  logic                 tok_valid_r;
  pps_pkg::scan_token_t tok_r;
  pps_pkg::scan_token_t tok_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic                 pending;
  logic                 ready;
  logic                 take;
  logic                 sel_load;
  logic                 sel_upd;

  assign sel_load = ctrl.load && (int'(item.entry_index) == POS);
  assign sel_upd  = ctrl.upd && (upd_idx == IDX_W'(POS));

  // entry takes part, is unfinished and has arrived
  assign pending = !done_r && (rem_r != 16'd0) && (POS < int'(pc));
  assign ready   = pending && ({5'd0, arr_r} <= cur_time);
  assign take    = ready && (!tok_in.found || (pri_r < tok_in.pri));

  // fold this entry into the passing candidate
  always_comb begin
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (pending && (tok_in.cnt != 2'd2)) begin
      tok_nxt.cnt = tok_in.cnt + 2'd1;
    end
    if (take) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.pri     = pri_r;
      tok_nxt.arrival = arr_r;
      tok_nxt.burst   = bur_r;
      tok_nxt.last    = (rem_r == 16'd1);
      idx_nxt         = IDX_W'(POS);
    end
  end

  // entry fields
  always_ff @(posedge clk) begin
    if (sel_load) begin
      arr_r <= item.arrival_time;
      bur_r <= item.burst_time;
      pri_r <= item.priority_req;
    end
    if (ctrl.restart) begin
      rem_r <= bur_r;
    end else if (sel_upd) begin
      rem_r <= rem_r - 16'd1;
    end
  end

  // completion mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (ctrl.restart) begin
      done_r <= 1'b0;
    end else if (sel_upd && (rem_r == 16'd1)) begin
      done_r <= 1'b1;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      tok_r <= tok_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign tok_out_valid = tok_valid_r;
  assign tok_out       = tok_r;
  assign idx_out       = idx_r;

endmodule
